// File: hdl/vcs_pkg.sv
// shared types and constants for the version compaction selector
// no dependencies
`timescale 1ns / 1ps

package vcs_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int EPOCH_W           = 4;
  localparam int QUEUE_DEPTH       = 4;
  localparam int CFG_IDX_W         = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_TIME = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERT_PER   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_PER     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VERSIONS = 8'd3;

  // classified slot waiting for the table walk
  typedef struct packed {
    logic        new_file;
    logic [63:0] doc_key;
    logic        tombstone;
    logic        older_revert;
    logic        older_keep;
  } job_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_CMP
  } back_state_t;

endpackage

// File: hdl/vcs_front.sv
// front end: takes slots and compares their time against both points
// depends on vcs_pkg
`timescale 1ns / 1ps

module vcs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              in_new_file,
  input  logic [63:0]       in_doc_key,
  input  logic [63:0]       in_slot_time,
  input  logic              in_tombstone,
  input  logic [63:0]       current_time,
  input  logic [63:0]       revert_period,
  input  logic [63:0]       keep_remove_period,
  input  logic              q_full,
  output logic              push,
  output vcs_pkg::job_t     push_data,
  output logic              front_busy
);

  logic        s1_v_r, s1_v_nxt;
  logic        s1_nf_r, s1_tomb_r;
  logic [63:0] s1_key_r, s1_time_r;
  logic        s2_v_r, s2_v_nxt;
  logic        s2_nf_r, s2_tomb_r;
  logic [63:0] s2_key_r, s2_time_r;
  logic [63:0] rev_pt_r, keep_pt_r;
  logic        s2_free, s1_move;

  assign s2_free  = !s2_v_r || !q_full;
  assign s1_move  = s1_v_r && s2_free;
  assign s1_v_nxt = accept || (s1_v_r && !s2_free);
  assign s2_v_nxt = s1_move || (s2_v_r && q_full);
  assign push     = s2_v_r && !q_full;
  assign front_busy = s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_nf_r   <= in_new_file;
      s1_key_r  <= in_doc_key;
      s1_time_r <= in_slot_time;
      s1_tomb_r <= in_tombstone;
    end
    if (s1_move) begin
      s2_nf_r   <= s1_nf_r;
      s2_key_r  <= s1_key_r;
      s2_time_r <= s1_time_r;
      s2_tomb_r <= s1_tomb_r;
      // points clamp at zero
      rev_pt_r  <= (current_time > revert_period) ? current_time - revert_period : 64'd0;
      keep_pt_r <= (current_time > keep_remove_period) ?
                   current_time - keep_remove_period : 64'd0;
    end
  end

  always_comb begin
    push_data.new_file     = s2_nf_r;
    push_data.doc_key      = s2_key_r;
    push_data.tombstone    = s2_tomb_r;
    push_data.older_revert = s2_time_r < rev_pt_r;
    push_data.older_keep   = s2_time_r < keep_pt_r;
  end

endmodule

// File: hdl/vcs_queue.sv
// small job queue between front end and table walker
// depends on vcs_pkg
`timescale 1ns / 1ps

module vcs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vcs_pkg::job_t push_data,
  input  logic          pop,
  output vcs_pkg::job_t pop_data,
  output logic          empty,
  output logic          full
);

  localparam int PTR_W = $clog2(vcs_pkg::QUEUE_DEPTH);

  vcs_pkg::job_t     mem_r [vcs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_r, rd_r;
  logic [PTR_W:0]    cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (PTR_W+1)'(vcs_pkg::QUEUE_DEPTH));
  assign pop_data = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(pop && !empty)) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop && !empty) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= wr_r + 1'b1;
      if (pop && !empty) rd_r <= rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

// File: hdl/vcs_back.sv
// back end: hashed key table walk with linear probing and epoch marks
// depends on vcs_pkg
`timescale 1ns / 1ps

module vcs_back #(
  parameter int TABLE_ENTRIES = vcs_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  vcs_pkg::job_t q_data,
  output logic          q_pop,
  input  logic [15:0]   max_versions,
  output logic          clearing,
  output logic          res_valid,
  output logic          res_remove,
  output logic [15:0]   res_version_index,
  output logic          res_table_full
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int FOLDS = (64 + IDX_W - 1) / IDX_W;
  localparam logic [IDX_W:0]   N_EXT   = (IDX_W+1)'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [vcs_pkg::EPOCH_W-1:0] EP_LAST = '1;

  logic [63:0]                 key_mem [TABLE_ENTRIES];
  logic [15:0]                 cnt_mem [TABLE_ENTRIES];
  logic [vcs_pkg::EPOCH_W-1:0] ep_mem  [TABLE_ENTRIES];

  vcs_pkg::back_state_t state_r, state_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [IDX_W:0]              probe_r, probe_nxt;
  logic [vcs_pkg::EPOCH_W-1:0] ep_r, ep_nxt;
  logic                        pend_r, pend_nxt;
  vcs_pkg::job_t               job_r;
  logic                        job_load;
  logic [63:0]                 rd_key;
  logic [15:0]                 rd_cnt;
  logic [vcs_pkg::EPOCH_W-1:0] rd_ep;
  logic                        data_we, ep_clr;
  logic [15:0]                 wr_cnt;
  logic                        hit, empty_slot;
  logic                        out_v_nxt, out_rm_nxt, out_full_nxt;
  logic [15:0]                 out_idx_nxt;
  logic [IDX_W-1:0]            idx_inc;

  function automatic logic [IDX_W-1:0] key_hash(input logic [63:0] key);
    logic [IDX_W-1:0] h;
    logic [63:0]      k;
    h = '0;
    k = key;
    for (int i = 0; i < FOLDS; i++) begin
      h = h ^ k[IDX_W-1:0];
      k = k >> IDX_W;
    end
    if ({1'b0, h} >= N_EXT) h = IDX_W'({1'b0, h} - N_EXT);
    return h;
  endfunction

  always_ff @(posedge clk) begin
    rd_key <= key_mem[idx_r];
    rd_cnt <= cnt_mem[idx_r];
    rd_ep  <= ep_mem[idx_r];
    if (data_we) begin
      key_mem[idx_r] <= job_r.doc_key;
      cnt_mem[idx_r] <= wr_cnt;
    end
    if (data_we || ep_clr) ep_mem[idx_r] <= ep_clr ? '0 : ep_r;
  end

  assign clearing   = (state_r == vcs_pkg::B_CLEAR);
  assign hit        = (rd_ep == ep_r) && (rd_key == job_r.doc_key);
  assign empty_slot = (rd_ep != ep_r);
  assign idx_inc    = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    probe_nxt    = probe_r;
    ep_nxt       = ep_r;
    pend_nxt     = pend_r;
    q_pop        = 1'b0;
    job_load     = 1'b0;
    data_we      = 1'b0;
    ep_clr       = 1'b0;
    wr_cnt       = 16'd1;
    out_v_nxt    = 1'b0;
    out_rm_nxt   = 1'b0;
    out_full_nxt = 1'b0;
    out_idx_nxt  = 16'd0;
    case (state_r)
      vcs_pkg::B_CLEAR: begin
        ep_clr = 1'b1;
        if (idx_r == IDX_LAST) begin
          ep_nxt = {{(vcs_pkg::EPOCH_W-1){1'b0}}, 1'b1};
          if (pend_r) begin
            pend_nxt  = 1'b0;
            idx_nxt   = key_hash(job_r.doc_key);
            probe_nxt = '0;
            state_nxt = vcs_pkg::B_READ;
          end else begin
            state_nxt = vcs_pkg::B_IDLE;
          end
        end else begin
          idx_nxt = idx_inc;
        end
      end
      vcs_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          job_load = 1'b1;
          if (q_data.new_file && ep_r == EP_LAST) begin
            // epochs used up: wipe the marks first
            pend_nxt  = 1'b1;
            idx_nxt   = '0;
            state_nxt = vcs_pkg::B_CLEAR;
          end else begin
            if (q_data.new_file) ep_nxt = ep_r + 1'b1;
            idx_nxt   = key_hash(q_data.doc_key);
            probe_nxt = '0;
            state_nxt = vcs_pkg::B_READ;
          end
        end
      end
      vcs_pkg::B_READ: begin
        state_nxt = vcs_pkg::B_CMP;
      end
      vcs_pkg::B_CMP: begin
        if (hit || empty_slot) begin
          data_we = 1'b1;
          if (hit) wr_cnt = (rd_cnt == 16'hFFFF) ? rd_cnt : rd_cnt + 16'd1;
          out_v_nxt   = 1'b1;
          out_idx_nxt = wr_cnt;
          if (wr_cnt > max_versions) out_rm_nxt = 1'b1;
          else if (wr_cnt != 16'd1) out_rm_nxt = job_r.older_revert;
          else out_rm_nxt = job_r.tombstone && job_r.older_keep && job_r.older_revert;
          state_nxt = vcs_pkg::B_IDLE;
        end else if (probe_r + 1'b1 == N_EXT) begin
          out_v_nxt    = 1'b1;
          out_full_nxt = 1'b1;
          state_nxt    = vcs_pkg::B_IDLE;
        end else begin
          probe_nxt = probe_r + 1'b1;
          idx_nxt   = idx_inc;
          state_nxt = vcs_pkg::B_READ;
        end
      end
      default: state_nxt = vcs_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= vcs_pkg::B_CLEAR;
      idx_r     <= '0;
      probe_r   <= '0;
      ep_r      <= '0;
      pend_r    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      probe_r   <= probe_nxt;
      ep_r      <= ep_nxt;
      pend_r    <= pend_nxt;
      res_valid <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) job_r <= q_data;
    if (out_v_nxt) begin
      res_remove        <= out_rm_nxt;
      res_version_index <= out_idx_nxt;
      res_table_full    <= out_full_nxt;
    end
  end

endmodule

// File: hdl/version_compaction_selector.sv
// top level of the version compaction selector: config registers, front end,
// job queue and table walker; depends on vcs_pkg, vcs_front, vcs_queue, vcs_back
`timescale 1ns / 1ps

// Marks each slot of a file, newest first, as kept or removed. A slot is taken
// when start is high and busy is low; its result appears for one cycle with
// out_valid high and cannot be held off. The front end registers the slot in
// stages s1 and s2 and compares the slot time with the revert and keep-remove
// points; s2 holds while the queue is full. The table walker then takes the job
// and, per probe of the hashed key table, steps through a read state and a
// compare state (one memory read port, registered). A four-entry queue decouples
// the two halves. After reset, and after every fifteenth new_file, a clearing
// pass walks all TABLE_ENTRIES entries and wipes the epoch marks; busy stays
// high during each such pass.
// Configuration writes are always accepted (cfg_ready is high) and must be
// done while no slot is in flight.

module version_compaction_selector #(
  parameter int TABLE_ENTRIES = vcs_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_new_file,
  input  logic [63:0]                   in_doc_key,
  input  logic [63:0]                   in_slot_time,
  input  logic                          in_tombstone,
  output logic                          out_valid,
  output logic                          out_remove,
  output logic [15:0]                   out_version_index,
  output logic                          out_table_full,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);

  // configuration registers
  logic [63:0] cur_time_r, rev_per_r, keep_per_r;
  logic [15:0] max_ver_r;

  logic          accept, front_busy, clearing;
  logic          push, pop, q_empty, q_full;
  vcs_pkg::job_t push_data, pop_data;

  assign cfg_ready = 1'b1;
  assign busy      = front_busy || clearing;
  assign accept    = start && !busy;

  // register write transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_time_r <= 64'd0;
      rev_per_r  <= 64'd0;
      keep_per_r <= 64'd0;
      max_ver_r  <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vcs_pkg::REG_CURRENT_TIME: cur_time_r <= cfg_data;
        vcs_pkg::REG_REVERT_PER:   rev_per_r  <= cfg_data;
        vcs_pkg::REG_KEEP_PER:     keep_per_r <= cfg_data;
        vcs_pkg::REG_MAX_VERSIONS: max_ver_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // time classification
  vcs_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept             (accept),
    .in_new_file        (in_new_file),
    .in_doc_key         (in_doc_key),
    .in_slot_time       (in_slot_time),
    .in_tombstone       (in_tombstone),
    .current_time       (cur_time_r),
    .revert_period      (rev_per_r),
    .keep_remove_period (keep_per_r),
    .q_full             (q_full),
    .push               (push),
    .push_data          (push_data),
    .front_busy         (front_busy)
  );

  vcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  // key table walk and decision
  vcs_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (pop_data),
    .q_pop             (pop),
    .max_versions      (max_ver_r),
    .clearing          (clearing),
    .res_valid         (out_valid),
    .res_remove        (out_remove),
    .res_version_index (out_version_index),
    .res_table_full    (out_table_full)
  );

endmodule
